// ===== src/madsr_pkg.sv =====
// Shared types and constants for the multichannel ADSR envelope bank.
// Request/result payload structs, channel state row, command, phase and sequencer codes.
// No dependencies.
`default_nettype none

package madsr_pkg;

    // Default geometry, used as the top-level parameter defaults
    localparam int CHANNELS_DEF   = 256;
    localparam int TICK_SHIFT_DEF = 13;
    localparam int MAX_STEPS_DEF  = 32;

    localparam logic [31:0] LONG_GAP  = 32'h0004_0000;
    localparam logic [30:0] LEVEL_MAX = 31'h7FFF_FFFF;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

    // Per-channel values after reset
    localparam logic [31:0] ATTACK_COEF_RST  = 32'd85046050;
    localparam logic [30:0] DECAY_COEF_RST   = 31'd42523025;
    localparam logic [31:0] RELEASE_COEF_RST = 32'd4277821740;
    localparam logic [30:0] SUSTAIN_RST      = 31'h1FFF_FFFF;

    typedef enum logic [2:0] {
        CMD_UPDATE  = 3'd0,
        CMD_GATE    = 3'd1,
        CMD_ATTACK  = 3'd2,
        CMD_DECAY   = 3'd3,
        CMD_SUSTAIN = 3'd4,
        CMD_RELEASE = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        PH_RELEASE = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_DECAY   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_MUL,
        ST_ACC,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  channel;
        logic [31:0] timer_now;
        logic [31:0] release_trim;
        logic        gate_level;
        logic        restart;
        logic [31:0] param_value;
    } t_in_req;

    typedef struct packed {
        logic [7:0]  out_channel;
        logic [15:0] level;
    } t_out_res;

    typedef struct packed {
        logic [30:0] env_level;
        logic [31:0] attack_coef;
        logic [30:0] decay_coef;
        logic [31:0] release_coef;
        logic [30:0] sustain_level;
        t_phase      phase;
        logic        gate_held;
        logic [31:0] last_time;
    } t_chan_row;

    localparam t_chan_row CHAN_ROW_RST = '{
        env_level:     31'd0,
        attack_coef:   ATTACK_COEF_RST,
        decay_coef:    DECAY_COEF_RST,
        release_coef:  RELEASE_COEF_RST,
        sustain_level: SUSTAIN_RST,
        phase:         PH_RELEASE,
        gate_held:     1'b0,
        last_time:     32'd0
    };

endpackage

`default_nettype wire

// ===== src/multichannel_adsr_envelope.sv =====
// Top level of the multichannel exponential ADSR envelope bank.
// Channel state memory, step sequencer and one shared 32x32 multiplier.
// Depends on madsr_pkg.
`default_nettype none

// Bank of CHANNELS exponential ADSR envelopes sharing one 32x32 multiplier.
// Every channel keeps its level, phase, held gate, last update time, its
// attack, decay and release coefficients and its sustain level in one row of
// an on-chip memory. Requests are taken one at a time: the addressed row is
// read, modified and written back. Gate and coefficient/sustain requests pass
// through a row state and a write state before the next request is taken.
// An update request runs n envelope steps (n from 0 up to MAX_STEPS, derived
// from the elapsed timer) between those two states: each step is one pass
// through the shared multiplier (operand select and multiply into a product
// register) followed by an accumulate state; a saturating attack step drops
// the rest. An update returns one result (channel and level >> 15); all other
// requests, codes 6 and 7, and channels at or above CHANNELS return nothing.
// Results sit in an output register, so a new request is taken while a result
// waits; only the write-back of a following update stalls until that register
// is free. After reset the block sweeps the memory to its reset values, one
// channel a cycle, and takes no requests during that pass.
module multichannel_adsr_envelope #(
    parameter int CHANNELS   = madsr_pkg::CHANNELS_DEF,
    parameter int TICK_SHIFT = madsr_pkg::TICK_SHIFT_DEF,
    parameter int MAX_STEPS  = madsr_pkg::MAX_STEPS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire madsr_pkg::t_in_req i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output madsr_pkg::t_out_res o_out_data
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int STEP_W = $clog2(MAX_STEPS + 1);

    // Channel state memory and its registered read port
    madsr_pkg::t_chan_row r_mem [CHANNELS];
    madsr_pkg::t_chan_row r_rd_row;

    madsr_pkg::t_state    r_state, n_state;
    logic [CH_W-1:0]      r_clr_idx, n_clr_idx;
    logic                 r_out_valid, n_out_valid;
    madsr_pkg::t_out_res  r_out, n_out;

    madsr_pkg::t_in_req   r_req, n_req;
    logic [CH_W-1:0]      r_idx, n_idx;
    madsr_pkg::t_chan_row r_wrow, n_wrow;
    logic [31:0]          r_rcoef, n_rcoef;
    logic [STEP_W-1:0]    r_steps, n_steps;
    logic [63:0]          r_prod, n_prod;

    logic                 w_in_fire;
    logic [31:0]          w_ch_ext;
    logic                 w_ch_ok;
    logic                 w_cmd_ok;
    logic [CH_W-1:0]      w_in_idx;
    logic                 w_mem_we;
    logic [CH_W-1:0]      w_mem_addr;
    madsr_pkg::t_chan_row w_mem_data;

    // Step count from elapsed time
    logic [31:0]          w_delta;
    logic [31:0]          w_raw_steps;
    logic [31:0]          w_clip_steps;

    // Shared multiplier operands and accumulate terms
    logic [31:0]          w_mul_a, w_mul_b;
    logic                 w_s_ge_l;
    logic [31:0]          w_hi;
    logic [31:0]          w_attack_sum;
    logic [31:0]          w_ceil_hi;
    logic [31:0]          w_decay_up, w_decay_dn;
    logic [30:0]          w_new_level;
    logic                 w_saturate;
    logic                 w_out_free;

    assign w_in_fire = i_in_valid && o_in_ready;
    assign w_ch_ext  = {24'd0, i_in_data.channel};
    assign w_ch_ok   = w_ch_ext < 32'(CHANNELS);
    assign w_in_idx  = w_ch_ext[CH_W-1:0];
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (madsr_pkg::t_cmd'(i_in_data.command))
            madsr_pkg::CMD_UPDATE, madsr_pkg::CMD_GATE, madsr_pkg::CMD_ATTACK,
            madsr_pkg::CMD_DECAY, madsr_pkg::CMD_SUSTAIN,
            madsr_pkg::CMD_RELEASE: w_cmd_ok = 1'b1;
            default:                w_cmd_ok = 1'b0;
        endcase
    end

    // Steps: a long gap counts as one step, else elapsed >> TICK_SHIFT, capped
    assign w_delta      = r_req.timer_now - r_rd_row.last_time;
    assign w_raw_steps  = (w_delta > madsr_pkg::LONG_GAP) ? 32'd1 : (w_delta >> TICK_SHIFT);
    assign w_clip_steps = (w_raw_steps > 32'(MAX_STEPS)) ? 32'(MAX_STEPS) : w_raw_steps;

    // Operand select for the shared multiplier, driven by the working row and r_rcoef
    assign w_s_ge_l = r_wrow.sustain_level >= r_wrow.env_level;

    always_comb begin
        case (r_wrow.phase)
            madsr_pkg::PH_ATTACK: begin
                w_mul_a = madsr_pkg::ALL_ONES - {1'b0, r_wrow.env_level};
                w_mul_b = r_wrow.attack_coef;
            end
            madsr_pkg::PH_DECAY: begin
                w_mul_a = w_s_ge_l ? {1'b0, r_wrow.sustain_level - r_wrow.env_level}
                                   : {1'b0, r_wrow.env_level - r_wrow.sustain_level};
                w_mul_b = {1'b0, r_wrow.decay_coef};
            end
            default: begin
                w_mul_a = {1'b0, r_wrow.env_level};
                w_mul_b = r_rcoef;
            end
        endcase
    end

    // Accumulate: attack adds the high word, decay moves toward sustain
    // (rounding the magnitude up when going down), release keeps the high word
    assign w_hi         = r_prod[63:32];
    assign w_attack_sum = {1'b0, r_wrow.env_level} + w_hi;
    assign w_ceil_hi    = w_hi + {31'd0, (r_prod[31:0] != 32'd0)};
    assign w_decay_up   = {1'b0, r_wrow.env_level} + w_hi;
    assign w_decay_dn   = {1'b0, r_wrow.env_level} - w_ceil_hi;

    always_comb begin
        w_saturate = 1'b0;
        case (r_wrow.phase)
            madsr_pkg::PH_ATTACK: begin
                w_saturate  = w_attack_sum[31];
                w_new_level = w_attack_sum[31] ? madsr_pkg::LEVEL_MAX : w_attack_sum[30:0];
            end
            madsr_pkg::PH_DECAY: begin
                w_new_level = w_s_ge_l ? w_decay_up[30:0] : w_decay_dn[30:0];
            end
            default: begin
                w_new_level = r_prod[62:32];
            end
        endcase
    end

    // Sequencer: next state and datapath
    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_req       = r_req;
        n_idx       = r_idx;
        n_wrow      = r_wrow;
        n_rcoef     = r_rcoef;
        n_steps     = r_steps;
        n_prod      = r_prod;
        o_in_ready  = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_addr  = r_idx;
        w_mem_data  = r_wrow;

        case (r_state)
            madsr_pkg::ST_CLEAR: begin
                w_mem_we   = 1'b1;
                w_mem_addr = r_clr_idx;
                w_mem_data = madsr_pkg::CHAN_ROW_RST;
                n_clr_idx  = r_clr_idx + 1'b1;
                if (r_clr_idx == CH_W'(CHANNELS - 1)) begin
                    n_state = madsr_pkg::ST_IDLE;
                end
            end
            madsr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (w_in_fire) begin
                    n_req = i_in_data;
                    n_idx = w_in_idx;
                    // drop unknown codes and channels beyond the bank
                    if (w_ch_ok && w_cmd_ok) begin
                        n_state = madsr_pkg::ST_ROW;
                    end
                end
            end
            madsr_pkg::ST_ROW: begin
                n_wrow  = r_rd_row;
                n_steps = '0;
                n_state = madsr_pkg::ST_WRITE;
                case (madsr_pkg::t_cmd'(r_req.command))
                    madsr_pkg::CMD_GATE: begin
                        if (r_req.gate_level && !r_rd_row.gate_held) begin
                            n_wrow.phase = madsr_pkg::PH_ATTACK;
                            if (r_req.restart) begin
                                n_wrow.env_level = '0;
                            end
                        end else if (!r_req.gate_level) begin
                            n_wrow.phase = madsr_pkg::PH_RELEASE;
                        end
                        n_wrow.gate_held = r_req.gate_level;
                    end
                    madsr_pkg::CMD_ATTACK:  n_wrow.attack_coef   = r_req.param_value;
                    madsr_pkg::CMD_DECAY:   n_wrow.decay_coef    = r_req.param_value[30:0];
                    madsr_pkg::CMD_SUSTAIN: n_wrow.sustain_level = r_req.param_value[31:1];
                    madsr_pkg::CMD_RELEASE: n_wrow.release_coef  = r_req.param_value;
                    madsr_pkg::CMD_UPDATE: begin
                        // phase code three runs as release
                        if (!(r_rd_row.phase inside {madsr_pkg::PH_ATTACK,
                                                     madsr_pkg::PH_DECAY})) begin
                            n_wrow.phase = madsr_pkg::PH_RELEASE;
                        end
                        n_rcoef = (r_rd_row.release_coef >= r_req.release_trim)
                                ? r_rd_row.release_coef - r_req.release_trim : 32'd0;
                        n_steps = w_clip_steps[STEP_W-1:0];
                        if (w_clip_steps != 32'd0) begin
                            n_wrow.last_time = r_req.timer_now;
                            n_state          = madsr_pkg::ST_MUL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            madsr_pkg::ST_MUL: begin
                n_prod  = w_mul_a * w_mul_b;
                n_state = madsr_pkg::ST_ACC;
            end
            madsr_pkg::ST_ACC: begin
                n_wrow.env_level = w_new_level;
                n_steps          = r_steps - 1'b1;
                if (w_saturate) begin
                    // attack done: drop remaining steps
                    n_wrow.phase = madsr_pkg::PH_DECAY;
                    n_state      = madsr_pkg::ST_WRITE;
                end else if (r_steps == STEP_W'(1)) begin
                    n_state = madsr_pkg::ST_WRITE;
                end else begin
                    n_state = madsr_pkg::ST_MUL;
                end
            end
            madsr_pkg::ST_WRITE: begin
                if (madsr_pkg::t_cmd'(r_req.command) == madsr_pkg::CMD_UPDATE) begin
                    // hold until the result register is free
                    if (w_out_free) begin
                        w_mem_we              = 1'b1;
                        n_out_valid           = 1'b1;
                        n_out.out_channel     = r_req.channel;
                        n_out.level           = r_wrow.env_level[30:15];
                        n_state               = madsr_pkg::ST_IDLE;
                    end
                end else begin
                    w_mem_we = 1'b1;
                    n_state  = madsr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = madsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= madsr_pkg::ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_req   <= n_req;
        r_idx   <= n_idx;
        r_wrow  <= n_wrow;
        r_rcoef <= n_rcoef;
        r_steps <= n_steps;
        r_prod  <= n_prod;
    end

    // Channel memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_data;
        end
        if (w_in_fire) begin
            r_rd_row <= r_mem[w_in_idx];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
